// ===== rtl/psdd_pkg.sv =====
// ----------------------------------------------------------------------------
// psdd_pkg
// Shared types and constants for the list-mode deframer: record kinds,
// header marks and the command that travels from the parser to the
// event processor.
// ----------------------------------------------------------------------------
package psdd_pkg;

  // Record kinds on the result channel.
  localparam logic [1:0] KIND_EVENT     = 2'd0;
  localparam logic [1:0] KIND_BAD_BOARD = 2'd1;
  localparam logic [1:0] KIND_BAD_CHAN  = 2'd2;

  // Header marks.
  localparam logic [3:0] BOARD_MARK = 4'hA;
  localparam logic [7:0] CHAN_MARK  = 8'h80;

  // Command queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One classified record, as handed from the parser to the event processor.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  chan;
    logic [30:0] tag;
    logic [15:0] ql;
    logic [14:0] qs;
  } psdd_cmd_t;

endpackage

// ===== rtl/psdd_front.sv =====
// ----------------------------------------------------------------------------
// psdd_front
// Stream parser. Walks board headers, channel headers and event word pairs
// and hands one command per record to the command queue.
// ----------------------------------------------------------------------------
module psdd_front #(
  parameter int MASK_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   word_valid,
  input  logic [31:0]            data_word,
  output logic                   word_ready,
  output logic                   cmd_valid,
  output psdd_pkg::psdd_cmd_t    cmd,
  input  logic                   cmd_ready
);
  import psdd_pkg::*;

  localparam int SLOT_W = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

  localparam logic [2:0] PH_BOARD    = 3'd0;
  localparam logic [2:0] PH_MASKWORD = 3'd1;
  localparam logic [2:0] PH_BDREST   = 3'd2;
  localparam logic [2:0] PH_CHHDR    = 3'd3;
  localparam logic [2:0] PH_CHEXTRA  = 3'd4;
  localparam logic [2:0] PH_EVFIRST  = 3'd5;
  localparam logic [2:0] PH_EVSECOND = 3'd6;

  logic [2:0]           phase, phase_next;
  logic [1:0]           hdr_left, hdr_left_next;
  logic [MASK_BITS-1:0] mask, mask_next;
  logic [SLOT_W-1:0]    slot, slot_next;
  logic [14:0]          events_left, events_left_next;
  logic [31:0]          first_word;

  logic [MASK_BITS-1:0] mask_cleared;
  logic                 any_kept, any_cleared;
  logic [SLOT_W-1:0]    low_kept, low_cleared;
  logic [14:0]          half;
  logic [14:0]          events_dec;
  logic                 accept;

  assign word_ready = cmd_ready;
  assign accept     = word_valid & cmd_ready;

  assign mask_cleared = mask & ~(MASK_BITS'(1) << slot);
  assign half         = data_word[15:1];
  assign events_dec   = events_left - 15'd1;

  // Lowest set bit of the mask as it stands, and after the current pair is
  // retired.
  always_comb begin
    any_kept    = 1'b0;
    any_cleared = 1'b0;
    low_kept    = '0;
    low_cleared = '0;
    for (int i = MASK_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        any_kept = 1'b1;
        low_kept = SLOT_W'(i);
      end
      if (mask_cleared[i]) begin
        any_cleared = 1'b1;
        low_cleared = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    hdr_left_next    = hdr_left;
    mask_next        = mask;
    slot_next        = slot;
    events_left_next = events_left;
    cmd_valid        = 1'b0;
    cmd              = '0;
    case (phase)
      PH_MASKWORD: begin
        mask_next     = data_word[MASK_BITS-1:0];
        hdr_left_next = 2'd2;
        phase_next    = PH_BDREST;
      end
      PH_BDREST: begin
        hdr_left_next = hdr_left - 2'd1;
        if (hdr_left_next == 2'd0) begin
          slot_next  = any_kept ? low_kept : '0;
          phase_next = any_kept ? PH_CHHDR : PH_BOARD;
        end
      end
      PH_CHHDR: begin
        if (data_word[31:24] != CHAN_MARK) begin
          cmd_valid  = word_valid;
          cmd.kind   = KIND_BAD_CHAN;
          cmd.chan   = 4'({slot, 1'b0});
          mask_next  = mask_cleared;
          slot_next  = any_cleared ? low_cleared : '0;
          phase_next = any_cleared ? PH_CHHDR : PH_BOARD;
        end else begin
          events_left_next = (half != 15'd0) ? half - 15'd1 : 15'd0;
          phase_next       = PH_CHEXTRA;
        end
      end
      PH_CHEXTRA: begin
        if (events_left != 15'd0) begin
          phase_next = PH_EVFIRST;
        end else begin
          mask_next  = mask_cleared;
          slot_next  = any_cleared ? low_cleared : '0;
          phase_next = any_cleared ? PH_CHHDR : PH_BOARD;
        end
      end
      PH_EVFIRST: begin
        phase_next = PH_EVSECOND;
      end
      PH_EVSECOND: begin
        cmd_valid        = word_valid;
        cmd.kind         = KIND_EVENT;
        cmd.chan         = 4'({slot, first_word[31]});
        cmd.tag          = first_word[30:0];
        cmd.ql           = data_word[31:16];
        cmd.qs           = data_word[14:0];
        events_left_next = events_dec;
        if (events_dec == 15'd0) begin
          mask_next  = mask_cleared;
          slot_next  = any_cleared ? low_cleared : '0;
          phase_next = any_cleared ? PH_CHHDR : PH_BOARD;
        end else begin
          phase_next = PH_EVFIRST;
        end
      end
      default: begin
        if (data_word[31:28] == BOARD_MARK) begin
          phase_next = PH_MASKWORD;
        end else begin
          cmd_valid  = word_valid;
          cmd.kind   = KIND_BAD_BOARD;
          phase_next = PH_BOARD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BOARD;
      hdr_left    <= 2'd0;
      mask        <= '0;
      slot        <= '0;
      events_left <= 15'd0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_left    <= hdr_left_next;
      mask        <= mask_next;
      slot        <= slot_next;
      events_left <= events_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_EVFIRST) begin
      first_word <= data_word;
    end
  end

endmodule

// ===== rtl/psdd_queue.sv =====
// ----------------------------------------------------------------------------
// psdd_queue
// Short command queue between the parser and the event processor.
// ----------------------------------------------------------------------------
module psdd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  psdd_pkg::psdd_cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output psdd_pkg::psdd_cmd_t pop_cmd,
  input  logic                pop_ready
);
  import psdd_pkg::*;

  psdd_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/psdd_back.sv =====
// ----------------------------------------------------------------------------
// psdd_back
// Event processor. Tracks the shared time tag and wrap count, computes the
// PSD ratio with a restoring divider and holds the result register.
// ----------------------------------------------------------------------------
module psdd_back #(
  parameter int PSD_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  psdd_pkg::psdd_cmd_t      cmd,
  output logic                     cmd_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               record_kind,
  output logic [3:0]               channel,
  output logic [30:0]              time_tag,
  output logic [31:0]              time_ext,
  output logic [30:0]              interval,
  output logic [15:0]              q_long,
  output logic [14:0]              q_short,
  output logic [PSD_FRAC_BITS:0]   psd_frac,
  output logic                     psd_valid
);
  import psdd_pkg::*;

  localparam int CNT_W = $clog2(PSD_FRAC_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [30:0] prev_tag;
  logic [31:0] wrap_count;

  // Pending record.
  logic [1:0]               pend_kind;
  logic [3:0]               pend_chan;
  logic [30:0]              pend_tag;
  logic [31:0]              pend_ext;
  logic [30:0]              pend_ivl;
  logic [15:0]              pend_ql;
  logic [14:0]              pend_qs;
  logic                     pend_valid;
  logic                     pend_full;

  // Divider.
  logic [15:0]              rem;
  logic [PSD_FRAC_BITS-1:0] quot;
  logic [CNT_W-1:0]         cnt;
  logic [16:0]              rem2;
  logic                     ge;

  logic        take;
  logic        is_event;
  logic        wraps;
  logic [31:0] wrap_next;
  logic        ratio_ok;
  logic        out_free;

  assign cmd_ready = (state == ST_IDLE);
  assign take      = cmd_valid & cmd_ready;
  assign is_event  = (cmd.kind == KIND_EVENT);
  assign wraps     = cmd.tag < prev_tag;
  assign wrap_next = wraps ? wrap_count + 32'd1 : wrap_count;
  assign ratio_ok  = cmd.ql > {1'b0, cmd.qs};
  assign out_free  = !out_valid || out_ready;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, pend_ql};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_tag   <= '0;
      wrap_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (is_event) begin
              prev_tag   <= cmd.tag;
              wrap_count <= wrap_next;
            end
            state <= (is_event && ratio_ok) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_kind  <= cmd.kind;
      pend_chan  <= cmd.chan;
      pend_tag   <= cmd.tag;
      pend_ql    <= cmd.ql;
      pend_qs    <= cmd.qs;
      pend_valid <= is_event && ratio_ok;
      pend_full  <= (cmd.qs == 15'd0);
      pend_ext   <= is_event ? wrap_next : '0;
      pend_ivl   <= (is_event && !wraps) ? cmd.tag - prev_tag : '0;
      rem        <= cmd.ql - {1'b0, cmd.qs};
      quot       <= '0;
      cnt        <= CNT_W'(PSD_FRAC_BITS - 1);
    end else if (state == ST_DIV) begin
      rem  <= ge ? 16'(rem2 - {1'b0, pend_ql}) : rem2[15:0];
      quot <= {quot[PSD_FRAC_BITS-2:0], ge};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  // A short charge of zero makes the ratio exactly one, which the fraction
  // bits alone cannot hold.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      record_kind <= pend_kind;
      channel     <= pend_chan;
      time_tag    <= pend_tag;
      time_ext    <= pend_ext;
      interval    <= pend_ivl;
      q_long      <= pend_ql;
      q_short     <= pend_qs;
      psd_frac    <= !pend_valid ? '0 :
                     pend_full   ? {1'b1, {PSD_FRAC_BITS{1'b0}}} : {1'b0, quot};
      psd_valid   <= pend_valid;
    end
  end

endmodule

// ===== rtl/psd_list_mode_deframer_top.sv =====
// Words that make no record go in at one per cycle while the command queue
// has space. A record with a PSD division holds the event processor while
// the divider makes one quotient bit per cycle. A four-entry queue absorbs
// bursts.
// Reset (rst, synchronous) returns the parser to awaiting a board header.
// ----------------------------------------------------------------------------
// psd_list_mode_deframer_top
// Deframes a digitizer list-mode readout stream into event and error records.
// ----------------------------------------------------------------------------
module psd_list_mode_deframer_top #(
  parameter int MASK_BITS     = 8,
  parameter int PSD_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            data_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             record_kind,
  output logic [3:0]             channel,
  output logic [30:0]            time_tag,
  output logic [31:0]            time_ext,
  output logic [30:0]            interval,
  output logic [15:0]            q_long,
  output logic [14:0]            q_short,
  output logic [PSD_FRAC_BITS:0] psd_frac,
  output logic                   psd_valid
);
  import psdd_pkg::*;

  // The parser classifies every input transfer. A word either advances the
  // header walk silently or completes a record, in which case a command is
  // pushed into the queue in the same cycle. The parser stalls only when the
  // queue is full, so in_ready follows the queue's free space.
  logic      fq_valid, fq_ready;
  psdd_cmd_t fq_cmd;

  // Commands leave the queue toward the event processor in arrival order,
  // which keeps the shared time tag and wrap count consistent.
  logic      qb_valid, qb_ready;
  psdd_cmd_t qb_cmd;

  psdd_front #(
    .MASK_BITS (MASK_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .word_valid (in_valid),
    .data_word  (data_word),
    .word_ready (in_ready),
    .cmd_valid  (fq_valid),
    .cmd        (fq_cmd),
    .cmd_ready  (fq_ready)
  );

  psdd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_cmd   (fq_cmd),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_cmd    (qb_cmd),
    .pop_ready  (qb_ready)
  );

  // The event processor owns the output register, so a stalled result never
  // blocks the parser while queue space remains.
  psdd_back #(
    .PSD_FRAC_BITS (PSD_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (qb_valid),
    .cmd         (qb_cmd),
    .cmd_ready   (qb_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .record_kind (record_kind),
    .channel     (channel),
    .time_tag    (time_tag),
    .time_ext    (time_ext),
    .interval    (interval),
    .q_long      (q_long),
    .q_short     (q_short),
    .psd_frac    (psd_frac),
    .psd_valid   (psd_valid)
  );

`ifndef ASSERT_OFF
  // Error records never carry a ratio or a wrap extension.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind != KIND_EVENT |-> !psd_valid && psd_frac == '0 && time_ext == '0)
    else $error("error record carries event data");

  // A valid ratio implies the long charge exceeds the short one.
  a_psd_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && psd_valid |-> q_long > {1'b0, q_short})
    else $error("psd_valid with q_long not above q_short");

  // The ratio never exceeds one, and it reaches one only with a zero short
  // charge.
  a_psd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && psd_frac[PSD_FRAC_BITS] |->
      psd_frac[PSD_FRAC_BITS-1:0] == '0 && q_short == '0)
    else $error("psd_frac out of range");
`endif

endmodule
